/* rtl/dlts_pkg.sv */
// shared types and constants for the delta list task scheduler
// no dependencies
package dlts_pkg;

	localparam int RESULT_LIMIT = 16;
	localparam int SLOT_OUT_W = 5;
	localparam int TAG_W = 16;
	localparam int DELAY_IN_W = 16;
	localparam int TARGET_W = 4;
	localparam int PEND_W = 8;

	typedef enum logic [1:0] {
		KIND_ADD  = 2'd0,
		KIND_DEL  = 2'd1,
		KIND_TICK = 2'd2,
		KIND_DSP  = 2'd3
	} kind_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_INS_WALK,
		ST_INS_LINK,
		ST_DEL,
		ST_RDY_WALK,
		ST_TMR_UNLINK,
		ST_FREE,
		ST_TICK,
		ST_DSP,
		ST_DSP_NEXT,
		ST_REPLY
	} state_t;

endpackage

/* rtl/delta_list_task_scheduler.sv */
// top level of the delta list task scheduler: slot table, sequencer and result register
// depends on dlts_pkg and dlts_alu
//
// channel  signals                                              dir
// cmd      cmd_valid cmd_stall kind start_delay repeat_period    in
//          task_tag target_slot
// res      res_valid res_stall slot_out success run_tag          out
//          last_result
//
// one item at a time; cmd_stall is low only while the sequencer is idle
// add: takes the free head and walks past at most SLOT_COUNT timer entries
// delete: a bad slot fails; else searches the ready list, else unlinks from the timer list
// tick: counts down the timer head; dispatch: per ready entry, an insert walk or a free
// the sequencer waits while res_stall holds the result register full
// reset restores the free chain and empties the timer and ready lists at once
module delta_list_task_scheduler #(
	parameter int SLOT_COUNT = 16,
	parameter int TICK_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	input  logic [15:0] task_tag,
	input  logic [3:0]  target_slot,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [4:0]  slot_out,
	output logic        success,
	output logic [15:0] run_tag,
	output logic        last_result
);

	localparam int LW = $clog2(SLOT_COUNT + 1);
	localparam int IW = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
	localparam int KMAX = (SLOT_COUNT > dlts_pkg::RESULT_LIMIT) ? SLOT_COUNT
		: dlts_pkg::RESULT_LIMIT;
	localparam int KW = $clog2(KMAX + 1);
	localparam logic [LW-1:0] NONE = LW'(SLOT_COUNT);
	localparam logic [32:0] TICK_MAX_W = (33'd1 << TICK_BITS) - 33'd1;
	localparam logic [dlts_pkg::PEND_W-1:0] PEND_MAX = '1;

	function automatic logic [TICK_BITS-1:0] clamp(input logic [15:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > TICK_MAX_W) ? TICK_BITS'(TICK_MAX_W) : TICK_BITS'(w);
	endfunction

	function automatic logic ok(input logic [LW-1:0] x);
		return x < NONE;
	endfunction

	logic [TICK_BITS-1:0]         delay_q  [SLOT_COUNT];
	logic [TICK_BITS-1:0]         period_q [SLOT_COUNT];
	logic [dlts_pkg::TAG_W-1:0]   stag_q   [SLOT_COUNT];
	logic [dlts_pkg::PEND_W-1:0]  pend_q   [SLOT_COUNT];
	logic [LW-1:0]                next_q   [SLOT_COUNT];
	logic [LW-1:0]                prev_q   [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]        occ_q;
	logic [LW-1:0]                thead_q, rhead_q, fhead_q;

	dlts_pkg::state_t state_q, state_d;
	dlts_pkg::kind_t  op_q;
	logic [15:0]      cstart_q, cper_q, ctag_q;
	logic [3:0]       ctgt_q;
	logic [LW-1:0]    w_q, cur_q, bef_q, rslot_q;
	logic             rok_q;
	logic [TICK_BITS-1:0] d_q;
	logic [KW-1:0]    ik_q, dk_q;

	logic             res_valid_q, res_ok_q, res_last_q;
	logic [4:0]       res_slot_q;
	logic [15:0]      res_tag_q;

	logic out_free, emit, e_ok, e_last;
	logic [LW-1:0] e_slot;
	logic [15:0] e_tag;

	logic [TICK_BITS-1:0] alu_a, alu_b, alu_res;
	dlts_pkg::alu_op_t    alu_op;
	logic                 alu_gt;

	logic [IW-1:0] ci, wi, fi, ri, ti, bi, pi, ni, hi;
	logic cur_ok, walk_go, rdy_go, dsp_go, tgt_bad;
	logic [LW-1:0] w_prev, w_next;

	assign ci = cur_q[IW-1:0];
	assign wi = w_q[IW-1:0];
	assign fi = fhead_q[IW-1:0];
	assign ri = rhead_q[IW-1:0];
	assign hi = thead_q[IW-1:0];
	assign bi = bef_q[IW-1:0];
	assign ti = IW'(ctgt_q);
	assign w_prev = prev_q[wi];
	assign w_next = next_q[wi];
	assign pi = w_prev[IW-1:0];
	assign ni = w_next[IW-1:0];
	assign cur_ok = ok(cur_q);
	assign walk_go = (ik_q < KW'(SLOT_COUNT)) && cur_ok && alu_gt;
	assign rdy_go = (ik_q < KW'(SLOT_COUNT)) && cur_ok;
	assign dsp_go = (dk_q < KW'(dlts_pkg::RESULT_LIMIT)) && ok(rhead_q);
	assign tgt_bad = (5'(ctgt_q) >= 5'(SLOT_COUNT)) || !occ_q[ti];
	assign out_free = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != dlts_pkg::ST_IDLE);

	dlts_alu #(.TICK_BITS(TICK_BITS)) u_alu (
		.a(alu_a), .b(alu_b), .op(alu_op), .res(alu_res), .gt(alu_gt)
	);

	always_comb begin
		alu_a = d_q;
		alu_b = cur_ok ? delay_q[ci] : '0;
		alu_op = dlts_pkg::ALU_SUB;
		unique case (state_q)
			dlts_pkg::ST_INS_LINK: begin
				alu_a = cur_ok ? delay_q[ci] : '0;
				alu_b = d_q;
			end
			dlts_pkg::ST_TMR_UNLINK: begin
				alu_a = ok(w_next) ? delay_q[ni] : '0;
				alu_b = delay_q[wi];
				alu_op = dlts_pkg::ALU_ADD;
			end
			dlts_pkg::ST_TICK: begin
				alu_a = ok(thead_q) ? delay_q[hi] : '0;
				alu_b = TICK_BITS'(1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlts_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (dlts_pkg::kind_t'(kind))
						dlts_pkg::KIND_ADD:  state_d = dlts_pkg::ST_ADD;
						dlts_pkg::KIND_DEL:  state_d = dlts_pkg::ST_DEL;
						dlts_pkg::KIND_TICK: state_d = dlts_pkg::ST_TICK;
						default:             state_d = dlts_pkg::ST_DSP;
					endcase
				end
			end
			dlts_pkg::ST_ADD:
				state_d = ok(fhead_q) ? dlts_pkg::ST_INS_WALK : dlts_pkg::ST_REPLY;
			dlts_pkg::ST_INS_WALK:
				state_d = walk_go ? dlts_pkg::ST_INS_WALK : dlts_pkg::ST_INS_LINK;
			dlts_pkg::ST_INS_LINK:
				state_d = (op_q == dlts_pkg::KIND_DSP) ? dlts_pkg::ST_DSP_NEXT
					: dlts_pkg::ST_REPLY;
			dlts_pkg::ST_DEL:
				state_d = tgt_bad ? dlts_pkg::ST_REPLY : dlts_pkg::ST_RDY_WALK;
			dlts_pkg::ST_RDY_WALK: begin
				if (!rdy_go) begin
					state_d = dlts_pkg::ST_TMR_UNLINK;
				end else if (cur_q == w_q) begin
					state_d = dlts_pkg::ST_FREE;
				end
			end
			dlts_pkg::ST_TMR_UNLINK: state_d = dlts_pkg::ST_FREE;
			dlts_pkg::ST_FREE:
				state_d = (op_q == dlts_pkg::KIND_DSP) ? dlts_pkg::ST_DSP_NEXT
					: dlts_pkg::ST_REPLY;
			dlts_pkg::ST_TICK: state_d = dlts_pkg::ST_REPLY;
			dlts_pkg::ST_DSP:
				state_d = ok(rhead_q) ? dlts_pkg::ST_DSP_NEXT : dlts_pkg::ST_REPLY;
			dlts_pkg::ST_DSP_NEXT: begin
				if (!dsp_go) begin
					state_d = dlts_pkg::ST_IDLE;
				end else if (out_free) begin
					state_d = (period_q[ri] != '0) ? dlts_pkg::ST_INS_WALK
						: dlts_pkg::ST_FREE;
				end
			end
			dlts_pkg::ST_REPLY: if (out_free) state_d = dlts_pkg::ST_IDLE;
			default: state_d = dlts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		e_slot = rslot_q;
		e_ok = rok_q;
		e_tag = '0;
		e_last = 1'b1;
		unique case (state_q)
			dlts_pkg::ST_REPLY: emit = out_free;
			dlts_pkg::ST_DSP_NEXT: begin
				emit = out_free && dsp_go;
				e_slot = rhead_q;
				e_ok = 1'b1;
				e_tag = stag_q[ri];
				e_last = (dk_q == KW'(dlts_pkg::RESULT_LIMIT - 1)) || !ok(next_q[ri]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_slot_q <= 5'(e_slot);
			res_ok_q <= e_ok;
			res_tag_q <= e_tag;
			res_last_q <= e_last;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dlts_pkg::ST_IDLE && cmd_valid) begin
			op_q <= dlts_pkg::kind_t'(kind);
			cstart_q <= start_delay;
			cper_q <= repeat_period;
			ctag_q <= task_tag;
			ctgt_q <= target_slot;
		end
		if (state_q == dlts_pkg::ST_ADD && ok(fhead_q)) begin
			stag_q[fi] <= ctag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				delay_q[i] <= '0;
				period_q[i] <= '0;
				pend_q[i] <= '0;
				next_q[i] <= LW'(i + 1);
				prev_q[i] <= NONE;
			end
			occ_q <= '0;
			thead_q <= NONE;
			rhead_q <= NONE;
			fhead_q <= '0;
			w_q <= NONE;
			cur_q <= NONE;
			bef_q <= NONE;
			rslot_q <= NONE;
			rok_q <= 1'b0;
			d_q <= '0;
			ik_q <= '0;
			dk_q <= '0;
		end else begin
			unique case (state_q)
				dlts_pkg::ST_ADD: begin
					if (ok(fhead_q)) begin
						fhead_q <= next_q[fi];
						next_q[fi] <= NONE;
						occ_q[fi] <= 1'b1;
						period_q[fi] <= clamp(cper_q);
						pend_q[fi] <= '0;
						d_q <= clamp(cstart_q);
						w_q <= fhead_q;
						cur_q <= thead_q;
						bef_q <= NONE;
						ik_q <= '0;
						rslot_q <= fhead_q;
						rok_q <= 1'b1;
					end else begin
						rslot_q <= NONE;
						rok_q <= 1'b0;
					end
				end
				dlts_pkg::ST_INS_WALK: begin
					if (walk_go) begin
						d_q <= alu_res;
						bef_q <= cur_q;
						cur_q <= next_q[ci];
						ik_q <= ik_q + 1'b1;
					end
				end
				dlts_pkg::ST_INS_LINK: begin
					prev_q[wi] <= bef_q;
					next_q[wi] <= cur_q;
					delay_q[wi] <= d_q;
					if (ok(bef_q)) begin
						next_q[bi] <= w_q;
					end else begin
						thead_q <= w_q;
					end
					if (cur_ok) begin
						prev_q[ci] <= w_q;
						delay_q[ci] <= alu_res;
					end
				end
				dlts_pkg::ST_DEL: begin
					if (tgt_bad) begin
						rslot_q <= NONE;
						rok_q <= 1'b0;
					end else begin
						rslot_q <= LW'(ctgt_q);
						rok_q <= 1'b1;
						w_q <= LW'(ctgt_q);
						cur_q <= rhead_q;
						bef_q <= NONE;
						ik_q <= '0;
					end
				end
				dlts_pkg::ST_RDY_WALK: begin
					if (rdy_go) begin
						if (cur_q == w_q) begin
							if (ok(bef_q)) begin
								next_q[bi] <= w_next;
							end else begin
								rhead_q <= w_next;
							end
						end else begin
							bef_q <= cur_q;
							cur_q <= next_q[ci];
							ik_q <= ik_q + 1'b1;
						end
					end
				end
				dlts_pkg::ST_TMR_UNLINK: begin
					if (ok(w_prev)) begin
						next_q[pi] <= w_next;
					end else begin
						thead_q <= w_next;
					end
					if (ok(w_next)) begin
						prev_q[ni] <= w_prev;
						delay_q[ni] <= alu_res;
					end
				end
				dlts_pkg::ST_FREE: begin
					occ_q[wi] <= 1'b0;
					period_q[wi] <= '0;
					pend_q[wi] <= '0;
					delay_q[wi] <= '0;
					prev_q[wi] <= NONE;
					next_q[wi] <= fhead_q;
					fhead_q <= w_q;
				end
				dlts_pkg::ST_TICK: begin
					rslot_q <= NONE;
					rok_q <= 1'b0;
					if (ok(thead_q)) begin
						delay_q[hi] <= alu_res;
						if (alu_res == '0) begin
							if (ok(next_q[hi])) begin
								prev_q[next_q[hi][IW-1:0]] <= NONE;
							end
							thead_q <= next_q[hi];
							if (pend_q[hi] != PEND_MAX) begin
								pend_q[hi] <= pend_q[hi] + 1'b1;
							end
							next_q[hi] <= rhead_q;
							prev_q[hi] <= NONE;
							rhead_q <= thead_q;
							rslot_q <= thead_q;
							rok_q <= 1'b1;
						end
					end
				end
				dlts_pkg::ST_DSP: begin
					rslot_q <= NONE;
					rok_q <= 1'b0;
					dk_q <= '0;
				end
				dlts_pkg::ST_DSP_NEXT: begin
					if (dsp_go && out_free) begin
						w_q <= rhead_q;
						rhead_q <= next_q[ri];
						next_q[ri] <= NONE;
						if (pend_q[ri] != '0) begin
							pend_q[ri] <= pend_q[ri] - 1'b1;
						end
						dk_q <= dk_q + 1'b1;
						d_q <= period_q[ri];
						cur_q <= thead_q;
						bef_q <= NONE;
						ik_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign slot_out = res_slot_q;
	assign success = res_ok_q;
	assign run_tag = res_tag_q;
	assign last_result = res_last_q;

	logic free_head_busy, ready_head_idle;
	assign free_head_busy = ok(fhead_q) && occ_q[fi];
	assign ready_head_idle = ok(rhead_q) && !occ_q[ri];

	a_free_head_unused: assert property (@(posedge clk) disable iff (!arst_n)
		!free_head_busy) else $error("free list head is occupied");

	a_ready_head_used: assert property (@(posedge clk) disable iff (!arst_n)
		!ready_head_idle) else $error("ready list head is not occupied");

	a_fail_marks_none: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !success |-> slot_out == 5'(SLOT_COUNT) && last_result)
		else $error("failed result without none marker");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("sequencer idle right after taking an item");

endmodule

/* rtl/dlts_alu.sv */
// shared delay unit: saturating add, floored subtract and greater-than compare
// depends on dlts_pkg
module dlts_alu #(
	parameter int TICK_BITS = 16
) (
	input  logic [TICK_BITS-1:0] a,
	input  logic [TICK_BITS-1:0] b,
	input  dlts_pkg::alu_op_t     op,
	output logic [TICK_BITS-1:0] res,
	output logic                  gt
);

	logic [TICK_BITS:0] sum;
	logic [TICK_BITS:0] diff;

	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = {1'b0, a} - {1'b0, b};
	assign gt   = !diff[TICK_BITS] && (diff[TICK_BITS-1:0] != '0);

	always_comb begin
		if (op == dlts_pkg::ALU_ADD) begin
			res = sum[TICK_BITS] ? '1 : sum[TICK_BITS-1:0];
		end else begin
			res = diff[TICK_BITS] ? '0 : diff[TICK_BITS-1:0];
		end
	end

endmodule

/* tb/tb_delta_list_task_scheduler.sv */
// testbench for the delta list task scheduler: random and directed command items,
// a behavioural copy of the slot table predicts every result item
// depends on dlts_pkg and the delta_list_task_scheduler rtl
module tb_delta_list_task_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam logic [4:0] NO_SLOT = 5'd16;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		dlts_pkg::kind_t kind;
		logic [15:0] start_delay;
		logic [15:0] repeat_period;
		logic [15:0] task_tag;
		logic [3:0] target_slot;
	} cmd_item_t;

	typedef struct packed {
		logic [4:0] slot_out;
		logic success;
		logic [15:0] run_tag;
		logic last_result;
	} res_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [1:0] kind = '0;
	logic [15:0] start_delay = '0;
	logic [15:0] repeat_period = '0;
	logic [15:0] task_tag = '0;
	logic [3:0] target_slot = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [4:0] slot_out;
	logic success;
	logic [15:0] run_tag;
	logic last_result;

	delta_list_task_scheduler dut (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.kind(kind), .start_delay(start_delay), .repeat_period(repeat_period),
		.task_tag(task_tag), .target_slot(target_slot), .res_valid(res_valid),
		.res_stall(res_stall), .slot_out(slot_out), .success(success),
		.run_tag(run_tag), .last_result(last_result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// scheduler copy
	logic [15:0] m_delay [SLOTS];
	logic [15:0] m_period [SLOTS];
	logic [15:0] m_tag [SLOTS];
	logic [7:0] m_runs [SLOTS];
	logic [4:0] m_next [SLOTS];
	logic [4:0] m_prev [SLOTS];
	logic m_used [SLOTS];
	logic [4:0] timer_head, ready_head, free_head;

	cmd_item_t pending_cmds[$];
	res_item_t expected_results[$];
	int fail_count = 0;
	int cycle_count = 0;
	int hold_off = 0;

	function automatic res_item_t mk(logic [4:0] s, logic ok, logic [15:0] t, logic l);
		res_item_t r;
		r.slot_out = s; r.success = ok; r.run_tag = t; r.last_result = l;
		return r;
	endfunction

	task automatic sched_reset();
		for (int i = 0; i < SLOTS; i++) begin
			m_delay[i] = 0; m_period[i] = 0; m_tag[i] = 0; m_runs[i] = 0;
			m_used[i] = 0; m_next[i] = 5'(i + 1); m_prev[i] = NO_SLOT;
		end
		timer_head = NO_SLOT; ready_head = NO_SLOT; free_head = 0;
	endtask

	task automatic free_slot(logic [4:0] s);
		m_used[s] = 0; m_tag[s] = 0; m_period[s] = 0; m_runs[s] = 0; m_delay[s] = 0;
		m_prev[s] = NO_SLOT; m_next[s] = free_head; free_head = s;
	endtask

	task automatic timer_insert(logic [4:0] s, logic [15:0] d_in);
		logic [4:0] cur, bef;
		logic [15:0] d;
		cur = timer_head; bef = NO_SLOT; d = d_in;
		for (int k = 0; k < SLOTS && cur != NO_SLOT && d > m_delay[cur]; k++) begin
			d -= m_delay[cur]; bef = cur; cur = m_next[cur];
		end
		m_prev[s] = bef; m_next[s] = cur; m_delay[s] = d;
		if (bef != NO_SLOT) m_next[bef] = s;
		else timer_head = s;
		if (cur != NO_SLOT) begin
			m_prev[cur] = s;
			m_delay[cur] = m_delay[cur] >= d ? m_delay[cur] - d : 16'd0;
		end
	endtask

	task automatic predict(cmd_item_t c);
		logic [4:0] s, p, n, cur, bef;
		logic [16:0] sum;
		bit found;
		int k;
		case (c.kind)
			dlts_pkg::KIND_ADD: begin
				s = free_head;
				if (s == NO_SLOT) expected_results.push_back(mk(NO_SLOT, 0, 0, 1));
				else begin
					free_head = m_next[s]; m_next[s] = NO_SLOT; m_used[s] = 1;
					m_tag[s] = c.task_tag; m_period[s] = c.repeat_period; m_runs[s] = 0;
					timer_insert(s, c.start_delay);
					expected_results.push_back(mk(s, 1, 0, 1));
				end
			end
			dlts_pkg::KIND_DEL: begin
				s = {1'b0, c.target_slot};
				if (!m_used[s]) expected_results.push_back(mk(NO_SLOT, 0, 0, 1));
				else begin
					found = 0; cur = ready_head; bef = NO_SLOT;
					for (k = 0; k < SLOTS && cur != NO_SLOT && !found; k++) begin
						if (cur == s) begin
							if (bef != NO_SLOT) m_next[bef] = m_next[s];
							else ready_head = m_next[s];
							found = 1;
						end else begin
							bef = cur; cur = m_next[cur];
						end
					end
					if (!found) begin
						p = m_prev[s]; n = m_next[s];
						if (p != NO_SLOT) m_next[p] = n;
						else timer_head = n;
						if (n != NO_SLOT) begin
							m_prev[n] = p;
							sum = m_delay[n] + m_delay[s];
							m_delay[n] = sum[16] ? 16'hffff : sum[15:0];
						end
					end
					free_slot(s);
					expected_results.push_back(mk(s, 1, 0, 1));
				end
			end
			dlts_pkg::KIND_TICK: begin
				s = timer_head; found = 0;
				if (s != NO_SLOT) begin
					if (m_delay[s] > 0) m_delay[s]--;
					if (m_delay[s] == 0) begin
						n = m_next[s];
						if (n != NO_SLOT) m_prev[n] = NO_SLOT;
						timer_head = n;
						if (m_runs[s] < 255) m_runs[s]++;
						m_next[s] = ready_head; m_prev[s] = NO_SLOT; ready_head = s;
						found = 1;
					end
				end
				expected_results.push_back(found ? mk(s, 1, 0, 1) : mk(NO_SLOT, 0, 0, 1));
			end
			default: begin
				if (ready_head == NO_SLOT) expected_results.push_back(mk(NO_SLOT, 0, 0, 1));
				else begin
					k = 0;
					while (k < dlts_pkg::RESULT_LIMIT && ready_head != NO_SLOT) begin
						s = ready_head;
						expected_results.push_back(mk(s, 1, m_tag[s], 0));
						ready_head = m_next[s]; m_next[s] = NO_SLOT;
						if (m_runs[s] > 0) m_runs[s]--;
						if (m_period[s] > 0) timer_insert(s, m_period[s]);
						else free_slot(s);
						k++;
					end
					expected_results[$].last_result = 1'b1;
				end
			end
		endcase
	endtask

	function automatic cmd_item_t new_cmd(dlts_pkg::kind_t k, int d, int p, int t, int sl);
		cmd_item_t c;
		c.kind = k; c.start_delay = 16'(d); c.repeat_period = 16'(p);
		c.task_tag = 16'(t); c.target_slot = 4'(sl);
		return c;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				predict(cmd_item_t'({kind, start_delay, repeat_period, task_tag, target_slot}));
				void'(pending_cmds.pop_front());
			end
			if (cmd_valid && cmd_stall) begin
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				cmd_valid <= 1'b0;
			end else if ((cmd_valid && !cmd_stall ? pending_cmds.size() : pending_cmds.size()) > 0
				&& !(cmd_valid && !cmd_stall && gap_len() > 0)) begin
				cmd_valid <= 1'b1;
				{kind, start_delay, repeat_period, task_tag, target_slot} <= pending_cmds[0];
			end else begin
				cmd_valid <= 1'b0;
				send_gap <= gap_len();
			end
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	// monitor and receiver
	always @(posedge clk) begin
		res_item_t e;
		int r;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) report_mismatch("unexpected item", slot_out, -1);
				else begin
					e = expected_results.pop_front();
					if (slot_out !== e.slot_out) report_mismatch("slot_out", slot_out, e.slot_out);
					if (success !== e.success) report_mismatch("success", success, e.success);
					if (run_tag !== e.run_tag) report_mismatch("run_tag", run_tag, e.run_tag);
					if (last_result !== e.last_result)
						report_mismatch("last_result", last_result, e.last_result);
				end
			end
			r = $urandom_range(0, 99);
			if (cycle_count == 1000) begin
				hold_off <= 400;
				res_stall <= 1'b1;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				res_stall <= 1'b1;
			end else if (r < 2) begin
				hold_off <= $urandom_range(8, 40);
				res_stall <= 1'b1;
			end else begin
				res_stall <= (r < 32);
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int n, r, sl;
		sched_reset();
		// directed part: extremes, fill table, full, a bad delete, a timer delete, dispatch
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_TICK, 0, 0, 0, 0));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_DSP, 0, 0, 0, 0));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_DEL, 0, 0, 0, 15));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_ADD, 0, 0, 16'hffff, 0));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_ADD, 16'hffff, 16'hffff, 16'h5a5a, 15));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_ADD, 1, 2, 16'h1234, 0));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_ADD, 0, 1, 16'h00ff, 0));
		for (int i = 0; i < 13; i++)
			pending_cmds.push_back(new_cmd(dlts_pkg::KIND_ADD, i % 3, i & 1, 16'ha000 + i, 0));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_ADD, 5, 5, 1, 0));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_TICK, 0, 0, 0, 0));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_TICK, 0, 0, 0, 0));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_DEL, 0, 0, 0, 0));
		pending_cmds.push_back(new_cmd(dlts_pkg::KIND_DSP, 0, 0, 0, 0));
		// random part, mostly small delays so tasks fire
		for (int i = 0; i < 305; i++) begin
			r = $urandom_range(0, 99);
			sl = $urandom_range(0, 15);
			if (r < 30)
				pending_cmds.push_back(new_cmd(dlts_pkg::KIND_ADD,
					($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6),
					($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5),
					$urandom, 0));
			else if (r < 45) pending_cmds.push_back(new_cmd(dlts_pkg::KIND_DEL, 0, 0, 0, sl));
			else if (r < 85) pending_cmds.push_back(new_cmd(dlts_pkg::KIND_TICK, $urandom,
				$urandom, $urandom, sl));
			else pending_cmds.push_back(new_cmd(dlts_pkg::KIND_DSP, 0, 0, 0, sl));
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_cmds.size() == 0 && !cmd_valid);
		wait (expected_results.size() == 0);
		n = 0;
		while (n < 200) begin
			@(posedge clk);
			n++;
		end
		if (fail_count == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end
endmodule
